// File: rtl/espc_pkg.sv
// Shared widths, codes and reset values for the encoder speed PI controller.
// No dependencies; compiled first.
package espc_pkg;

   // payload and register widths
   localparam int unsigned OP_W          = 1;
   localparam int unsigned PERIOD_W      = 16;
   localparam int unsigned TARGET_W      = 14;
   localparam int unsigned GAIN_W        = 8;
   localparam int unsigned KI_W          = 16;
   localparam int unsigned BAND_W        = 8;
   localparam int unsigned DUTY_W        = 8;
   localparam int unsigned SPEED_W       = 17;
   localparam int unsigned ERR_W         = 18;
   localparam int unsigned INTEG_W       = 24;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = 16;

   // datapath widths
   localparam int unsigned DEN_W         = PERIOD_W;
   localparam int unsigned SPEED_CONST_W = 20;
   localparam int unsigned PROD_W        = INTEG_W + KI_W + 1;
   localparam int unsigned PTERM_W       = GAIN_W + 1 + ERR_W;
   localparam int unsigned DRIVE_W       = PTERM_W + 1;

   // defaults of the top-level parameters
   localparam int unsigned RING_DEPTH_DEF     = 32;
   localparam int unsigned PRESCALE_SHIFT_DEF = 3;

   localparam logic [SPEED_CONST_W-1:0] SPEED_CONST = 20'd625000;
   localparam logic [SPEED_W-1:0]       SPEED_MAX   = 17'h1FFFF;
   localparam logic [DUTY_W-1:0]        DUTY_MAX    = 8'd255;

   // register reset values
   localparam logic [TARGET_W-1:0] TARGET_RST = 14'd60;
   localparam logic [PERIOD_W-1:0] MIN_PER_RST = 16'd400;
   localparam logic [PERIOD_W-1:0] MAX_PER_RST = 16'd65535;
   localparam logic [GAIN_W-1:0]   KP_RST      = 8'd1;
   localparam logic [KI_W-1:0]     KI_RST      = 16'd655;
   localparam logic [BAND_W-1:0]   BAND_RST    = 8'd10;

   typedef enum logic [OP_W-1:0] {
      OP_PERIOD = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_SPEED = 3'd0,
      CSR_MIN_PERIOD   = 3'd1,
      CSR_MAX_PERIOD   = 3'd2,
      CSR_KP           = 3'd3,
      CSR_KI_Q16       = 3'd4,
      CSR_LED_BAND     = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RING_WR,
      ST_DIV_AVG,
      ST_AVG_DONE,
      ST_DIV_SPD,
      ST_SPD_DONE,
      ST_PI,
      ST_MUL,
      ST_DRIVE
   } state_type;

endpackage

// File: rtl/espc_if.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on espc_pkg.
interface espc_req_if import espc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [PERIOD_W-1:0] period_ticks;

   modport source (output valid, op, period_ticks, input ready);
   modport sink   (input valid, op, period_ticks, output ready);
endinterface

interface espc_rsp_if import espc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       duty;
   logic [SPEED_W-1:0]      speed;
   logic signed [ERR_W-1:0] speed_error;
   logic                    far_flag;
   logic                    on_target;

   modport source (output valid, duty, speed, speed_error, far_flag, on_target,
                   input ready);
   modport sink   (input valid, duty, speed, speed_error, far_flag, on_target,
                   output ready);
endinterface

interface espc_csr_if import espc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/encoder_speed_pi_controller_unit.sv
// Encoder speed PI controller: period ring, serial divider and PI datapath.
// Depends on espc_pkg and the channel interfaces in espc_if.sv.

// A period transaction (op 0) inside the open window (min_period, max_period)
// is written into a RING_DEPTH-entry ring held in a synchronous memory; the old
// entry is read back on acceptance and the new one written in RING_WR, so that a
// running sum of the ring stays current. A period outside the window is dropped
// and gives no response. A tick transaction (op 1) forms the ring average by a
// multiply with a rounded-up reciprocal of RING_DEPTH, then divides 625000 by it
// in a restoring divider of N = max(16 + clog2(RING_DEPTH), 20) bits, one
// quotient bit a cycle. A tick steps through DIV_AVG, AVG_DONE, DIV_SPD,
// SPD_DONE, PI, MUL and DRIVE; the response is loaded in DRIVE and the next
// transaction is taken in the cycle after. A zero average skips the divider. A
// response still waiting on the output holds the block in its last step until
// the response register frees. Ring entries start as zero through per-entry
// valid bits, so no clearing pass follows reset. Register writes are always
// taken and belong to idle periods only, which the user, not the block, ensures.
module encoder_speed_pi_controller_unit
   import espc_pkg::*;
#(
   parameter int unsigned RING_DEPTH     = RING_DEPTH_DEF,
   parameter int unsigned PRESCALE_SHIFT = PRESCALE_SHIFT_DEF
) (
   input  logic     clock,
   input  logic     reset,
   espc_req_if.sink   req_ch,
   espc_rsp_if.source rsp_ch,
   espc_csr_if.sink   csr_ch
);

   localparam int unsigned IDX_W = $clog2(RING_DEPTH);
   localparam int unsigned SUM_W = PERIOD_W + $clog2(RING_DEPTH);
   localparam int unsigned NUM_W = (SUM_W > SPEED_CONST_W) ? SUM_W : SPEED_CONST_W;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);
   // sum / RING_DEPTH as (sum * AVG_MUL) >> AVG_SHIFT, exact for any SUM_W-bit sum
   localparam int unsigned AVG_SHIFT = SUM_W + IDX_W;
   localparam int unsigned MUL_W     = SUM_W + 1;
   localparam logic [MUL_W-1:0] AVG_MUL =
      MUL_W'(((longint'(1) <<< AVG_SHIFT) / RING_DEPTH) + 1);

   // configuration registers
   logic [TARGET_W-1:0] target_ff;
   logic [PERIOD_W-1:0] min_per_ff;
   logic [PERIOD_W-1:0] max_per_ff;
   logic [GAIN_W-1:0]   kp_ff;
   logic [KI_W-1:0]     ki_ff;
   logic [BAND_W-1:0]   band_ff;

   state_type state_ff, state_in;

   // ring storage
   logic [PERIOD_W-1:0]   ring_mem [RING_DEPTH];
   logic [PERIOD_W-1:0]   ring_rd_ff;
   logic [RING_DEPTH-1:0] ring_valid_ff;
   logic [IDX_W-1:0]      ring_idx_ff;
   logic [SUM_W-1:0]      ring_sum_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic [PERIOD_W-1:0]   ring_old;
   logic [IDX_W-1:0]      ring_idx_in;

   // divider
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] div_cnt_ff;
   logic [DEN_W:0]   rem_sh;
   logic             div_ge;
   logic             div_last;
   logic [SUM_W+MUL_W-1:0] avg_prod;

   // PI datapath
   logic [SPEED_W-1:0]        speed_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic                      far_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PTERM_W-1:0] pterm_ff;

   logic [NUM_W-1:0]          quo_sh;
   logic [PERIOD_W-1:0]       avg;
   logic signed [ERR_W-1:0]   err_in;
   logic [ERR_W-1:0]          err_mag;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [PROD_W-1:0]  prod_adj;
   logic signed [PROD_W-17:0] iterm;
   logic signed [DRIVE_W-1:0] drive_sum;
   logic [DUTY_W-1:0]         duty_in;

   // response register
   logic                    rsp_valid_ff;
   logic [DUTY_W-1:0]       rsp_duty_ff;
   logic [SPEED_W-1:0]      rsp_speed_ff;
   logic signed [ERR_W-1:0] rsp_err_ff;
   logic                    rsp_far_ff;
   logic                    rsp_on_ff;

   // control
   logic req_ready;
   logic req_take;
   logic period_ok;
   logic out_free;
   logic out_load;

   assign req_take  = req_ch.valid && req_ready;
   assign period_ok = (req_ch.period_ticks > min_per_ff) && (req_ch.period_ticks < max_per_ff);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_ch.op == OP_TICK) begin
                  state_in = ST_DIV_AVG;
               end else if (period_ok) begin
                  state_in = ST_RING_WR;
               end
            end
         end
         ST_RING_WR:  state_in = ST_IDLE;
         ST_DIV_AVG:  state_in = ST_AVG_DONE;
         ST_AVG_DONE: state_in = (avg == '0) ? ST_PI : ST_DIV_SPD;
         ST_DIV_SPD:  if (div_last) state_in = ST_SPD_DONE;
         ST_SPD_DONE: state_in = ST_PI;
         ST_PI:       state_in = ST_MUL;
         ST_MUL:      state_in = ST_DRIVE;
         ST_DRIVE:    if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_DRIVE: out_load  = out_free;
         default: begin
            req_ready = 1'b0;
            out_load  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- configuration ----------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= TARGET_RST;
         min_per_ff <= MIN_PER_RST;
         max_per_ff <= MAX_PER_RST;
         kp_ff      <= KP_RST;
         ki_ff      <= KI_RST;
         band_ff    <= BAND_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_TARGET_SPEED: target_ff  <= csr_ch.data[TARGET_W-1:0];
            CSR_MIN_PERIOD:   min_per_ff <= csr_ch.data[PERIOD_W-1:0];
            CSR_MAX_PERIOD:   max_per_ff <= csr_ch.data[PERIOD_W-1:0];
            CSR_KP:           kp_ff      <= csr_ch.data[GAIN_W-1:0];
            CSR_KI_Q16:       ki_ff      <= csr_ch.data[KI_W-1:0];
            CSR_LED_BAND:     band_ff    <= csr_ch.data[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- period ring ----------------
   // Read the entry about to be replaced on acceptance, write the new period over it next cycle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         ring_rd_ff <= ring_mem[ring_idx_ff];
      end
      if (state_ff == ST_RING_WR) begin
         ring_mem[ring_idx_ff] <= period_ff;
      end
   end

   assign ring_old    = ring_valid_ff[ring_idx_ff] ? ring_rd_ff : '0;
   assign ring_idx_in = (ring_idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : ring_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (req_take) begin
         period_ff <= req_ch.period_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         ring_idx_ff   <= '0;
         ring_sum_ff   <= '0;
      end else if (state_ff == ST_RING_WR) begin
         ring_valid_ff[ring_idx_ff] <= 1'b1;
         ring_idx_ff <= ring_idx_in;
         ring_sum_ff <= ring_sum_ff - SUM_W'(ring_old) + SUM_W'(period_ff);
      end
   end

   // ---------------- average and serial divider ----------------
   assign avg_prod = quo_ff[SUM_W-1:0] * AVG_MUL;
   assign rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
   assign div_ge   = rem_sh >= {1'b0, den_ff};
   assign div_last = div_cnt_ff == CNT_W'(NUM_W - 1);
   assign avg      = quo_ff[PERIOD_W-1:0];
   assign quo_sh   = quo_ff >> PRESCALE_SHIFT;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         quo_ff     <= NUM_W'(ring_sum_ff);
      end else if (state_ff == ST_DIV_AVG) begin
         quo_ff     <= NUM_W'(avg_prod >> AVG_SHIFT);
      end else if (state_ff == ST_AVG_DONE) begin
         den_ff     <= avg;
         quo_ff     <= NUM_W'(SPEED_CONST);
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (state_ff == ST_DIV_SPD) begin
         quo_ff     <= {quo_ff[NUM_W-2:0], div_ge};
         rem_ff     <= div_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_AVG_DONE) begin
         speed_ff <= '0;
      end else if (state_ff == ST_SPD_DONE) begin
         speed_ff <= (quo_sh > NUM_W'(SPEED_MAX)) ? SPEED_MAX : quo_sh[SPEED_W-1:0];
      end
   end

   // ---------------- PI step ----------------
   assign err_in    = $signed(ERR_W'(target_ff)) - $signed(ERR_W'(speed_ff));
   assign err_mag   = err_in[ERR_W-1] ? ERR_W'(-err_in) : err_in;
   assign integ_sum = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(err_in);

   always_comb begin
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_in = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         far_ff   <= 1'b0;
      end else if (state_ff == ST_PI) begin
         integ_ff <= integ_in;
         if (err_mag > ERR_W'(band_ff)) begin
            far_ff <= 1'b1;
         end else if (err_mag < ERR_W'(band_ff)) begin
            far_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PI) begin
         err_ff <= err_in;
      end
      if (state_ff == ST_MUL) begin
         prod_ff  <= PROD_W'(integ_ff) * PROD_W'($signed({1'b0, ki_ff}));
         pterm_ff <= PTERM_W'($signed({1'b0, kp_ff})) * PTERM_W'(err_ff);
      end
   end

   // bias a negative product so the shift rounds toward zero
   assign prod_adj  = prod_ff + $signed({{(PROD_W-KI_W){1'b0}}, {KI_W{prod_ff[PROD_W-1]}}});
   assign iterm     = prod_adj[PROD_W-1:16];
   assign drive_sum = DRIVE_W'(pterm_ff) + DRIVE_W'(iterm);

   always_comb begin
      if (drive_sum < 0) begin
         duty_in = '0;
      end else if (drive_sum > $signed(DRIVE_W'(DUTY_MAX))) begin
         duty_in = DUTY_MAX;
      end else begin
         duty_in = drive_sum[DUTY_W-1:0];
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_duty_ff  <= duty_in;
         rsp_speed_ff <= speed_ff;
         rsp_err_ff   <= err_ff;
         rsp_far_ff   <= far_ff;
         rsp_on_ff    <= (err_ff == '0);
      end
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.duty        = rsp_duty_ff;
   assign rsp_ch.speed       = rsp_speed_ff;
   assign rsp_ch.speed_error = rsp_err_ff;
   assign rsp_ch.far_flag    = rsp_far_ff;
   assign rsp_ch.on_target   = rsp_on_ff;

endmodule

// File: rtl/espc_checker.sv
// Port-level checks on the encoder speed PI controller, bound to the top level.
// Depends on espc_pkg and encoder_speed_pi_controller_unit.
module espc_checker
   import espc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [DUTY_W-1:0]       rsp_duty,
   input logic signed [ERR_W-1:0] rsp_speed_error,
   input logic                    rsp_far_flag,
   input logic                    rsp_on_target
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty) && $stable(rsp_speed_error))
      else $error("response changed while stalled");

   a_on_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_on_target == (rsp_speed_error == '0))
      else $error("on_target disagrees with speed_error");

   // band is at most 255, so a larger error must flag far
   a_far_big: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_speed_error > 18'sd255 || rsp_speed_error < -18'sd255)
      |-> rsp_far_flag)
      else $error("far_flag low for large error");

   // valid drops only after a transaction has been taken
   a_valid_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("response withdrawn without a handshake");

endmodule

bind encoder_speed_pi_controller_unit espc_checker u_espc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_duty        (rsp_ch.duty),
   .rsp_speed_error (rsp_ch.speed_error),
   .rsp_far_flag    (rsp_ch.far_flag),
   .rsp_on_target   (rsp_ch.on_target)
);
